/* design/qdc_pkg.sv */
// shared types, constants and helpers for the quadrature detent counter
package qdc_pkg;

    localparam int CountW = 8;
    localparam int PinsW = 2;
    localparam int AddrW = 3;
    localparam int DataW = 32;

    localparam logic [CountW-1:0] MaxCountReset = 8'd99;
    localparam logic [AddrW-1:0] RegMaxCount = 3'd0;

    // 2/3 as a fixed-point reciprocal, 11 fraction bits, exact for counts up to 255
    localparam int DriveShift = 11;
    localparam int DriveProdW = 19;
    localparam logic [DriveProdW-1:0] DriveRecip = 19'd1366;

    typedef struct packed {
        logic [CountW-1:0] count;
        logic              changed;
    } t_lane_res;

    function automatic logic [CountW-1:0] f_drive(input logic [CountW-1:0] count);
        logic [DriveProdW-1:0] prod;
        prod = DriveProdW'(count) * DriveRecip;
        return prod[DriveShift +: CountW];
    endfunction

endpackage

/* design/qdc_lane.sv */
// one lane: detent state machine and saturating count
module qdc_lane
    import qdc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [PinsW-1:0]    i_pins,
    input  logic                i_enable,
    input  logic [CountW-1:0]   i_max_count,
    output t_lane_res           o_res
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_AFIRST = 5'b00010,
        S_AARMED = 5'b00100,
        S_BFIRST = 5'b01000,
        S_BARMED = 5'b10000
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [CountW-1:0] r_count, n_count;
    logic              n_changed;
    logic              a_on, b_on;

    assign a_on = ~i_pins[0];
    assign b_on = ~i_pins[1];

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_changed = 1'b0;
        unique case (r_phase)
            S_IDLE: begin
                if (a_on) begin
                    n_phase = S_AFIRST;
                end else if (b_on) begin
                    n_phase = S_BFIRST;
                end
            end
            S_AFIRST: begin
                if (!a_on) begin
                    n_phase = S_IDLE;
                end else if (b_on) begin
                    n_phase = S_AARMED;
                end
            end
            S_AARMED: begin
                if (!b_on) begin
                    n_phase = S_IDLE;
                    if (i_enable && (r_count < i_max_count)) begin
                        n_count   = r_count + CountW'(1);
                        n_changed = 1'b1;
                    end
                end
            end
            S_BFIRST: begin
                if (!b_on) begin
                    n_phase = S_IDLE;
                end else if (a_on) begin
                    n_phase = S_BARMED;
                end
            end
            S_BARMED: begin
                if (!a_on) begin
                    n_phase = S_IDLE;
                    if (i_enable && (r_count != '0)) begin
                        n_count   = r_count - CountW'(1);
                        n_changed = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= S_IDLE;
            r_count <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    assign o_res.count   = n_count;
    assign o_res.changed = n_changed;

    a_count_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_count))
        else $error("lane count moved without a transaction");

    a_count_single_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> (r_count == $past(r_count)) ||
                     (r_count == $past(r_count) + 8'd1) ||
                     (r_count == $past(r_count) - 8'd1))
        else $error("lane count moved by more than one");

endmodule

/* design/qdc_merge.sv */
// merges lane results into one output transaction behind a skid stage
module qdc_merge
    import qdc_pkg::*;
#(
    parameter int LANES = 4,
    parameter int OutW  = 72
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_lane_res         i_lane [LANES],
    input  logic              i_stopped,
    input  logic              i_m_tready,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    output logic [OutW-1:0]   o_m_tdata
);

    logic [OutW-1:0] new_data;
    logic [LANES-1:0] changed;

    logic            r_out_valid, r_skid_valid;
    logic [OutW-1:0] r_out_data, r_skid_data;
    logic            out_free;

    always_comb begin
        new_data = '0;
        for (int i = 0; i < LANES; i++) begin
            new_data[CountW*i +: CountW]         = i_lane[i].count;
            new_data[CountW*(LANES+i) +: CountW] = f_drive(i_lane[i].count);
            changed[i]                           = i_lane[i].changed;
        end
        new_data[2*CountW*LANES] = (|changed) & i_stopped;
    end

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_accept;
            end
        end else if (i_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (i_accept) begin
                r_out_data <= new_data;
            end
        end else if (i_accept) begin
            r_skid_data <= new_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds data while output register is empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_m_tready) |=> r_skid_valid && $stable(r_skid_data))
        else $error("skid stage lost or changed data while stalled");

endmodule

/* design/quadrature_detent_counter.sv */
// top level: lane array, merging stage and configuration register
// a result is registered in the output register, or in the skid register on a stall
// throughput: one transaction per cycle while the skid register is empty
// a two-entry output stage (register plus skid) keeps ready high until the skid fills
// reset is synchronous and active low: phases go idle, counts to 0, max_count to 99
module quadrature_detent_counter
    import qdc_pkg::*;
#(
    parameter int  LANES = 4,
    localparam int InW   = ((3*LANES + 1 + 7) / 8) * 8,
    localparam int OutW  = ((2*CountW*LANES + 1 + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // pins_lane0..N-1 (2 bits each), enable_lane0..N-1, generator_stopped, zero pad
    input  logic [InW-1:0]     s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // count_lane0..N-1, drive_lane0..N-1 (8 bits each), test_pulse_request, zero pad
    output logic [OutW-1:0]    m_axis_tdata,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [AddrW-1:0]   paddr,
    input  logic [DataW-1:0]   pwdata,
    output logic [DataW-1:0]   prdata,
    output logic               pready
);

    logic              accept;
    logic [CountW-1:0] r_max_count;
    t_lane_res         lane_res [LANES];

    assign accept = s_axis_tvalid && s_axis_tready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_count <= MaxCountReset;
        end else if (psel && penable && pwrite && pready
                     && (paddr[AddrW-1:2] == RegMaxCount[AddrW-1:2])) begin
            r_max_count <= pwdata[CountW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[AddrW-1:2] == RegMaxCount[AddrW-1:2]) begin
            prdata = {{(DataW-CountW){1'b0}}, r_max_count};
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        qdc_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_accept    (accept),
            .i_pins      (s_axis_tdata[PinsW*g +: PinsW]),
            .i_enable    (s_axis_tdata[PinsW*LANES + g]),
            .i_max_count (r_max_count),
            .o_res       (lane_res[g])
        );
    end

    qdc_merge #(
        .LANES (LANES),
        .OutW  (OutW)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_lane     (lane_res),
        .i_stopped  (s_axis_tdata[3*LANES]),
        .i_m_tready (m_axis_tready),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule
